/* rtl/hmmc_pkg.sv */
package hmmc_pkg;

  // Default width of the signed temperature samples.
  localparam int unsigned TEMP_WIDTH_DEF = 12;

  localparam int unsigned THRESH_W = 7;
  localparam int unsigned MENU_W   = 2;
  localparam int unsigned STEP_W   = 4;
  localparam int unsigned CFG_W    = 7;

  // Run mode codes.
  typedef enum logic [1:0] {
    MODE_OFF  = 2'd0,
    MODE_ON   = 2'd1,
    MODE_FILL = 2'd2
  } mode_e;

  // Menu item codes.
  localparam logic [MENU_W-1:0] MENU_WATER = 2'd1;
  localparam logic [MENU_W-1:0] MENU_AIR   = 2'd2;
  localparam logic [MENU_W-1:0] MENU_FILL  = 2'd3;

  // Configuration register indexes.
  localparam logic CFG_FLOOR   = 1'b0;
  localparam logic CFG_CEILING = 1'b1;

  // Reset values.
  localparam logic [CFG_W-1:0]    FLOOR_RST   = 7'd20;
  localparam logic [CFG_W-1:0]    CEILING_RST = 7'd80;
  localparam logic [THRESH_W-1:0] WATER_RST   = 7'd35;
  localparam logic [THRESH_W-1:0] AIR_RST     = 7'd40;

  // Controller state; the result word is taken straight from it.
  typedef struct packed {
    mode_e               run_mode;
    logic [MENU_W-1:0]   menu;
    logic                edit;
    logic                prev_sw;
    logic [THRESH_W-1:0] water_th;
    logic [THRESH_W-1:0] air_th;
    logic                pump;
    logic                diverter;
    logic                valve;
    logic                fill_ind;
  } state_t;

  localparam state_t STATE_RST = '{
    run_mode: MODE_OFF,
    menu:     MENU_WATER,
    edit:     1'b0,
    prev_sw:  1'b0,
    water_th: WATER_RST,
    air_th:   AIR_RST,
    pump:     1'b0,
    diverter: 1'b0,
    valve:    1'b0,
    fill_ind: 1'b0
  };

  // Threshold limits as seen by the update logic.
  typedef struct packed {
    logic [CFG_W-1:0] floor_th;
    logic [CFG_W-1:0] ceiling_th;
  } limits_t;

endpackage

/* rtl/hmmc_if.sv */
// Control pass word channel.
interface hmmc_in_if #(
  parameter int unsigned TEMP_WIDTH = hmmc_pkg::TEMP_WIDTH_DEF
);
  logic                         valid;
  logic                         ready;
  logic                         switch_on;
  logic                         knob_press;
  logic                         knob_turned;
  logic signed [3:0]            turn_step;
  logic signed [TEMP_WIDTH-1:0] water_temp;
  logic signed [TEMP_WIDTH-1:0] air_temp;
  logic                         tank_full;

  modport source (
    output valid, switch_on, knob_press, knob_turned, turn_step,
           water_temp, air_temp, tank_full,
    input  ready
  );
  modport sink (
    input  valid, switch_on, knob_press, knob_turned, turn_step,
           water_temp, air_temp, tank_full,
    output ready
  );
endinterface

// Result word channel.
interface hmmc_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] run_mode;
  logic [1:0] menu_item;
  logic       editing;
  logic [6:0] water_thresh;
  logic [6:0] air_thresh;
  logic       pump_on;
  logic       diverter_open;
  logic       valve_open;
  logic       filling;

  modport source (
    output valid, run_mode, menu_item, editing, water_thresh, air_thresh,
           pump_on, diverter_open, valve_open, filling,
    input  ready
  );
  modport sink (
    input  valid, run_mode, menu_item, editing, water_thresh, air_thresh,
           pump_on, diverter_open, valve_open, filling,
    output ready
  );
endinterface

/* rtl/heater_mode_menu_controller_top.sv */
// Accepted words wait in the input stage, then pass into the result register.
// Throughput: one control pass per cycle while the sink keeps up; the state
// update is one registered pass through the update logic, and a stalled
// sink holds the input stage back through ready in the same cycle.
// Reset: asynchronous, active low; clears the stage valids and loads the
// mode off, menu item 1, thresholds 35 and 40, floor 20 and ceiling 80.
module heater_mode_menu_controller_top #(
  parameter int unsigned TEMP_WIDTH = hmmc_pkg::TEMP_WIDTH_DEF
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    cfg_we_i,
  input  logic                    cfg_idx_i,
  input  logic [hmmc_pkg::CFG_W-1:0] cfg_data_i,
  hmmc_in_if.sink                 in_i,
  hmmc_out_if.source              out_o
);
  import hmmc_pkg::*;

  limits_t                lim_q;
  state_t                 st_q;
  state_t                 st_d;
  logic                   in_valid_q;
  logic                   out_valid_q;
  logic                   process;
  logic                   sw_q;
  logic                   press_q;
  logic                   turned_q;
  logic signed [3:0]      step_q;
  logic [TEMP_WIDTH-1:0]  water_q;
  logic [TEMP_WIDTH-1:0]  air_q;
  logic                   full_q;
  state_t                 res_q;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lim_q.floor_th   <= FLOOR_RST;
      lim_q.ceiling_th <= CEILING_RST;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == CFG_FLOOR) begin
        lim_q.floor_th <= cfg_data_i;
      end else begin
        lim_q.ceiling_th <= cfg_data_i;
      end
    end
  end

  // The input word moves on when the result register is free or being drained.
  assign process     = in_valid_q && (!out_valid_q || out_o.ready);
  assign in_i.ready  = !in_valid_q || process;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      in_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      sw_q     <= in_i.switch_on;
      press_q  <= in_i.knob_press;
      turned_q <= in_i.knob_turned;
      step_q   <= in_i.turn_step;
      water_q  <= in_i.water_temp;
      air_q    <= in_i.air_temp;
      full_q   <= in_i.tank_full;
    end
  end

  hmmc_pass #(
    .TEMP_WIDTH (TEMP_WIDTH)
  ) u_pass (
    .state_i       (st_q),
    .limits_i      (lim_q),
    .switch_on_i   (sw_q),
    .knob_press_i  (press_q),
    .knob_turned_i (turned_q),
    .turn_step_i   (step_q),
    .water_temp_i  (water_q),
    .air_temp_i    (air_q),
    .tank_full_i   (full_q),
    .state_o       (st_d)
  );

  // Controller state advances once per processed word.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= STATE_RST;
    end else if (process) begin
      st_q <= st_d;
    end
  end

  // Result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (process) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (process) begin
      res_q <= st_d;
    end
  end

  assign out_o.valid         = out_valid_q;
  assign out_o.run_mode      = res_q.run_mode;
  assign out_o.menu_item     = res_q.menu;
  assign out_o.editing       = res_q.edit;
  assign out_o.water_thresh  = res_q.water_th;
  assign out_o.air_thresh    = res_q.air_th;
  assign out_o.pump_on       = res_q.pump;
  assign out_o.diverter_open = res_q.diverter;
  assign out_o.valve_open    = res_q.valve;
  assign out_o.filling       = res_q.fill_ind;

  // The valve is open exactly while fill mode is held.
  a_valve_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    st_q.valve == (st_q.run_mode == MODE_FILL))
    else $error("valve state disagrees with run mode");

  // Off mode leaves every relay released.
  a_off_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q.run_mode == MODE_OFF) |-> (!st_q.pump && !st_q.diverter && !st_q.valve))
    else $error("relay driven in off mode");

  // The menu item never leaves its range.
  a_menu_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    st_q.menu != 2'd0)
    else $error("menu item out of range");

  // A new result appears only after a word was waiting in the input stage.
  a_out_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(in_valid_q))
    else $error("result word without an input word");

endmodule

/* rtl/hmmc_pass.sv */
module hmmc_pass #(
  parameter int unsigned TEMP_WIDTH = hmmc_pkg::TEMP_WIDTH_DEF
) (
  input  hmmc_pkg::state_t        state_i,
  input  hmmc_pkg::limits_t       limits_i,
  input  logic                    switch_on_i,
  input  logic                    knob_press_i,
  input  logic                    knob_turned_i,
  input  logic signed [3:0]       turn_step_i,
  input  logic [TEMP_WIDTH-1:0]   water_temp_i,
  input  logic [TEMP_WIDTH-1:0]   air_temp_i,
  input  logic                    tank_full_i,
  output hmmc_pkg::state_t        state_o
);
  import hmmc_pkg::*;

  // Compare width: covers the sample and sixteen times a 7-bit threshold.
  localparam int unsigned CW = (TEMP_WIDTH > 12) ? TEMP_WIDTH : 12;

  logic signed [CW-1:0] water_ext;
  logic signed [CW-1:0] air_ext;
  logic signed [CW-1:0] water_lim;
  logic signed [CW-1:0] air_lim;
  logic signed [4:0]    menu_sum;
  logic signed [8:0]    th_sum;
  logic signed [8:0]    floor_ext;
  logic signed [8:0]    ceil_ext;
  logic [THRESH_W-1:0]  th_sel;
  logic [THRESH_W-1:0]  th_new;
  state_t               s;

  assign water_ext = CW'($signed(water_temp_i));
  assign air_ext   = CW'($signed(air_temp_i));
  assign floor_ext = $signed({2'b00, limits_i.floor_th});
  assign ceil_ext  = $signed({2'b00, limits_i.ceiling_th});

  // Threshold adjust target is chosen by the menu item before the turn.
  assign th_sel = (state_i.menu == MENU_AIR) ? state_i.air_th : state_i.water_th;
  assign th_sum = $signed({2'b00, th_sel}) + 9'(turn_step_i);

  // Clamp; when crossed, sums over the ceiling take it, all others the floor.
  always_comb begin
    if (th_sum > ceil_ext) begin
      th_new = limits_i.ceiling_th;
    end else if (th_sum < floor_ext) begin
      th_new = limits_i.floor_th;
    end else begin
      th_new = th_sum[THRESH_W-1:0];
    end
  end

  // One control pass: switch edge, press, turn, fill item, mode action.
  always_comb begin
    s        = state_i;
    menu_sum = $signed({3'b000, state_i.menu}) + 5'(turn_step_i);

    if (switch_on_i != state_i.prev_sw) begin
      s.prev_sw  = switch_on_i;
      s.run_mode = switch_on_i ? MODE_ON : MODE_OFF;
    end

    if (knob_press_i && !(state_i.menu == MENU_FILL && switch_on_i)) begin
      s.edit = !state_i.edit;
    end

    if (knob_turned_i) begin
      if (!s.edit) begin
        if (menu_sum > 5'sd3) begin
          s.menu = MENU_FILL;
        end else if (menu_sum < 5'sd1) begin
          s.menu = MENU_WATER;
        end else begin
          s.menu = menu_sum[MENU_W-1:0];
        end
      end else if (state_i.menu == MENU_WATER) begin
        s.water_th = th_new;
      end else if (state_i.menu == MENU_AIR) begin
        s.air_th = th_new;
      end
    end

    if (s.menu == MENU_FILL) begin
      if (s.edit && !switch_on_i) begin
        s.fill_ind = 1'b1;
        s.run_mode = MODE_FILL;
      end else begin
        s.fill_ind = 1'b0;
        s.run_mode = switch_on_i ? MODE_ON : MODE_OFF;
      end
    end

    water_lim = $signed({{(CW-11){1'b0}}, s.water_th, 4'b0000});
    air_lim   = $signed({{(CW-11){1'b0}}, s.air_th, 4'b0000});

    // Mode action on the latched outputs; equality holds pump and diverter.
    unique case (s.run_mode)
      MODE_OFF: begin
        s.pump     = 1'b0;
        s.diverter = 1'b0;
        s.valve    = 1'b0;
      end
      MODE_ON: begin
        s.valve = 1'b0;
        if (air_ext > air_lim) begin
          s.pump = 1'b1;
        end else if (air_ext < air_lim) begin
          s.pump = 1'b0;
        end
        if (water_ext < water_lim) begin
          s.diverter = 1'b1;
        end else if (water_ext > water_lim) begin
          s.diverter = 1'b0;
        end
      end
      MODE_FILL: begin
        s.valve = 1'b1;
        if (tank_full_i) begin
          s.edit = 1'b0;
        end
      end
      default: begin
        s.run_mode = state_i.run_mode;
      end
    endcase

    state_o = s;
  end

endmodule

/* test/hmmc_pass_checker.sv */
`timescale 1ns / 1ps

// Watches the pass and result channels, predicts each result word from the
// accepted control passes and compares the words in order.
module hmmc_pass_checker
  import hmmc_pkg::*;
#(
  parameter int unsigned TEMP_W = TEMP_WIDTH_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic             cfg_idx_i,
  input  logic [CFG_W-1:0] cfg_data_i,
  hmmc_in_if               pass_i,
  hmmc_out_if              word_i,
  output int unsigned      fail_count_o,
  output int unsigned      pending_o,
  output int unsigned      checked_o,
  output int unsigned      fill_words_o
);

  // One predicted result word.
  typedef struct packed {
    mode_e               run_mode;
    logic [MENU_W-1:0]   menu;
    logic                edit;
    logic [THRESH_W-1:0] water_th;
    logic [THRESH_W-1:0] air_th;
    logic                pump;
    logic                diverter;
    logic                valve;
    logic                fill;
  } word_t;

  // Predicted controller state and threshold limits.
  mode_e               mode_q;
  logic [MENU_W-1:0]   menu_q;
  logic                edit_q;
  logic                sw_q;
  logic [THRESH_W-1:0] water_th_q;
  logic [THRESH_W-1:0] air_th_q;
  logic                pump_q;
  logic                diverter_q;
  logic                valve_q;
  logic                fill_q;
  logic [CFG_W-1:0]    floor_q;
  logic [CFG_W-1:0]    ceil_q;

  word_t       expected_words[$];
  word_t       exp_word;
  int unsigned fails;
  int unsigned checked;
  int unsigned fill_words;

  // With crossed limits, sums over the ceiling take it, all others the floor.
  function automatic logic [THRESH_W-1:0] clamp_limit(input int v);
    if (v > int'(ceil_q)) return ceil_q;
    if (v < int'(floor_q)) return floor_q;
    return THRESH_W'(v);
  endfunction

  // Applies one control pass to the predicted state and returns the word.
  function automatic word_t run_control_pass(
    input logic                     sw,
    input logic                     press,
    input logic                     turned,
    input logic signed [3:0]        step,
    input logic signed [TEMP_W-1:0] water,
    input logic signed [TEMP_W-1:0] air,
    input logic                     full
  );
    int    menu_sum;
    int    air_lim;
    int    water_lim;
    word_t w;
    // A switch edge sets the mode from the new level.
    if (sw != sw_q) begin
      sw_q   = sw;
      mode_q = sw ? MODE_ON : MODE_OFF;
    end
    // Press toggles editing, except on the fill item with the switch on.
    if (press && !(menu_q == MENU_FILL && sw)) begin
      edit_q = !edit_q;
    end
    // Turn moves the menu, or edits the selected threshold.
    if (turned) begin
      if (!edit_q) begin
        menu_sum = int'(menu_q) + int'(step);
        if (menu_sum > 3) menu_sum = 3;
        else if (menu_sum < 1) menu_sum = 1;
        menu_q = MENU_W'(menu_sum);
      end else if (menu_q == MENU_WATER) begin
        water_th_q = clamp_limit(int'(water_th_q) + int'(step));
      end else if (menu_q == MENU_AIR) begin
        air_th_q = clamp_limit(int'(air_th_q) + int'(step));
      end
    end
    // The fill item arms fill mode while editing with the switch off.
    if (menu_q == MENU_FILL) begin
      if (edit_q && !sw) begin
        fill_q = 1'b1;
        mode_q = MODE_FILL;
      end else begin
        fill_q = 1'b0;
        mode_q = sw ? MODE_ON : MODE_OFF;
      end
    end
    // Mode action on the latched outputs; equality holds pump and diverter.
    case (mode_q)
      MODE_OFF: begin
        pump_q     = 1'b0;
        diverter_q = 1'b0;
        valve_q    = 1'b0;
      end
      MODE_ON: begin
        air_lim   = int'(air_th_q) * 16;
        water_lim = int'(water_th_q) * 16;
        valve_q   = 1'b0;
        if (int'(air) > air_lim) pump_q = 1'b1;
        else if (int'(air) < air_lim) pump_q = 1'b0;
        if (int'(water) < water_lim) diverter_q = 1'b1;
        else if (int'(water) > water_lim) diverter_q = 1'b0;
      end
      MODE_FILL: begin
        valve_q = 1'b1;
        if (full) edit_q = 1'b0;
      end
      default: begin
      end
    endcase
    w.run_mode = mode_q;
    w.menu     = menu_q;
    w.edit     = edit_q;
    w.water_th = water_th_q;
    w.air_th   = air_th_q;
    w.pump     = pump_q;
    w.diverter = diverter_q;
    w.valve    = valve_q;
    w.fill     = fill_q;
    return w;
  endfunction

  task automatic check_field(input string name, input int unsigned exp_v,
                             input int unsigned act_v);
    if (exp_v != act_v) begin
      $error("%s: expected %0d, got %0d", name, exp_v, act_v);
      fails++;
    end
  endtask

  // Configuration, result comparison and prediction, in edge order.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q      = MODE_OFF;
      menu_q      = MENU_WATER;
      edit_q      = 1'b0;
      sw_q        = 1'b0;
      water_th_q  = WATER_RST;
      air_th_q    = AIR_RST;
      pump_q      = 1'b0;
      diverter_q  = 1'b0;
      valve_q     = 1'b0;
      fill_q      = 1'b0;
      floor_q     = FLOOR_RST;
      ceil_q      = CEILING_RST;
      fails       = 0;
      checked     = 0;
      fill_words  = 0;
      expected_words.delete();
      pending_o    <= 0;
      fail_count_o <= 0;
      checked_o    <= 0;
      fill_words_o <= 0;
    end else begin
      if (cfg_we_i) begin
        if (cfg_idx_i == CFG_FLOOR) floor_q = cfg_data_i;
        else ceil_q = cfg_data_i;
      end
      if (word_i.valid && word_i.ready) begin
        if (expected_words.size() == 0) begin
          $error("result word arrived with no control pass waiting");
          fails++;
        end else begin
          exp_word = expected_words.pop_front();
          checked++;
          if (exp_word.run_mode == MODE_FILL) fill_words++;
          check_field("run_mode", exp_word.run_mode, word_i.run_mode);
          check_field("menu_item", exp_word.menu, word_i.menu_item);
          check_field("editing", exp_word.edit, word_i.editing);
          check_field("water_thresh", exp_word.water_th, word_i.water_thresh);
          check_field("air_thresh", exp_word.air_th, word_i.air_thresh);
          check_field("pump_on", exp_word.pump, word_i.pump_on);
          check_field("diverter_open", exp_word.diverter, word_i.diverter_open);
          check_field("valve_open", exp_word.valve, word_i.valve_open);
          check_field("filling", exp_word.fill, word_i.filling);
        end
      end
      if (pass_i.valid && pass_i.ready) begin
        expected_words.push_back(run_control_pass(
          pass_i.switch_on, pass_i.knob_press, pass_i.knob_turned,
          pass_i.turn_step, pass_i.water_temp, pass_i.air_temp,
          pass_i.tank_full));
      end
      pending_o    <= expected_words.size();
      fail_count_o <= fails;
      checked_o    <= checked;
      fill_words_o <= fill_words;
    end
  end

endmodule

/* test/tb_heater_mode_menu_controller_top.sv */
`timescale 1ns / 1ps

module tb_heater_mode_menu_controller_top;
  import hmmc_pkg::*;

  localparam int unsigned TEMP_W        = TEMP_WIDTH_DEF;
  localparam int          TEMP_MIN      = -880;
  localparam int          TEMP_MAX      = 2000;
  localparam int          NUM_PHASES    = 8;
  localparam int          RANDOM_PASSES = 216;

  // Limit settings and idle mixes per phase; the last phase draws its limits.
  localparam int FLOOR_TBL[NUM_PHASES] = '{20, 0, 127, 50, 0, 127, 30, 0};
  localparam int CEIL_TBL[NUM_PHASES]  = '{80, 127, 0, 50, 0, 127, 45, 0};
  localparam int SEND_TBL[NUM_PHASES]  = '{0, 86, 0, 36, 0, 86, 0, 36};
  localparam int STALL_TBL[NUM_PHASES] = '{0, 0, 86, 36, 0, 0, 86, 36};

  logic             clk;
  logic             rst_n;
  logic             cfg_we;
  logic             cfg_idx;
  logic [CFG_W-1:0] cfg_data;
  logic             take_word = 1'b0;

  int unsigned fail_count;
  int unsigned pending_words;
  int unsigned checked_words;
  int unsigned fill_words;

  int   send_pct  = 0;
  int   stall_pct = 0;
  int   lim_lo    = 20;
  int   lim_hi    = 80;
  logic sw_level  = 1'b0;

  hmmc_in_if #(.TEMP_WIDTH(TEMP_W)) pass_if ();
  hmmc_out_if                       word_if ();

  assign word_if.ready = take_word;

  heater_mode_menu_controller_top #(
    .TEMP_WIDTH(TEMP_W)
  ) i_dut (
    .clk_i     (clk),
    .rst_ni    (rst_n),
    .cfg_we_i  (cfg_we),
    .cfg_idx_i (cfg_idx),
    .cfg_data_i(cfg_data),
    .in_i      (pass_if),
    .out_o     (word_if)
  );

  hmmc_pass_checker #(
    .TEMP_W(TEMP_W)
  ) i_checker (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_data_i  (cfg_data),
    .pass_i      (pass_if),
    .word_i      (word_if),
    .fail_count_o(fail_count),
    .pending_o   (pending_words),
    .checked_o   (checked_words),
    .fill_words_o(fill_words)
  );

  // Clock generation.
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Result side stalls at the rate of the current phase.
  always @(posedge clk) begin
    take_word <= ($urandom_range(0, 99) >= stall_pct);
  end

  // Hard stop in case the handshake hangs.
  initial begin
    #2_000_000;
    $display("Mismatches found");
    $finish;
  end

  // Offers one control pass after a random gap and waits until it is taken.
  task automatic send_pass(input logic sw, input logic press, input logic turned,
                           input int step, input int water, input int air,
                           input logic full);
    while ($urandom_range(0, 99) < send_pct) begin
      pass_if.valid <= 1'b0;
      @(posedge clk);
    end
    pass_if.valid       <= 1'b1;
    pass_if.switch_on   <= sw;
    pass_if.knob_press  <= press;
    pass_if.knob_turned <= turned;
    pass_if.turn_step   <= 4'(step);
    pass_if.water_temp  <= TEMP_W'(water);
    pass_if.air_temp    <= TEMP_W'(air);
    pass_if.tank_full   <= full;
    @(posedge clk);
    while (!pass_if.ready) @(posedge clk);
  endtask

  // Stops offering passes until every predicted word has come back.
  task automatic drain();
    pass_if.valid <= 1'b0;
    @(posedge clk);
    while (pending_words != 0) @(posedge clk);
  endtask

  // Writes both threshold limits on consecutive edges.
  task automatic write_limits(input int fl, input int ce);
    cfg_we   <= 1'b1;
    cfg_idx  <= CFG_FLOOR;
    cfg_data <= CFG_W'(fl);
    @(posedge clk);
    cfg_idx  <= CFG_CEILING;
    cfg_data <= CFG_W'(ce);
    @(posedge clk);
    cfg_we <= 1'b0;
    lim_lo = (fl < ce) ? fl : ce;
    lim_hi = (fl < ce) ? ce : fl;
  endtask

  // Temperatures cluster on the threshold grid so that equality is hit.
  function automatic int pick_temp();
    int t;
    case ($urandom_range(0, 3))
      0: t = TEMP_MIN + int'($urandom_range(0, TEMP_MAX - TEMP_MIN));
      3: t = ($urandom_range(0, 1) == 1) ? TEMP_MIN : TEMP_MAX;
      default: t = 16 * int'($urandom_range(lim_lo, lim_hi))
                   + int'($urandom_range(0, 4)) - 2;
    endcase
    if (t > TEMP_MAX) t = TEMP_MAX;
    if (t < TEMP_MIN) t = TEMP_MIN;
    return t;
  endfunction

  // Mostly plausible operator activity, with some fully random passes.
  task automatic send_random();
    logic sw;
    logic press;
    logic turned;
    logic full;
    int   step;
    if ($urandom_range(0, 99) < 15) begin
      sw     = 1'($urandom);
      press  = 1'($urandom);
      turned = 1'($urandom);
      full   = 1'($urandom);
      step   = int'($urandom_range(0, 15)) - 8;
    end else begin
      if ($urandom_range(0, 7) == 0) sw_level = !sw_level;
      sw     = sw_level;
      press  = ($urandom_range(0, 3) == 0);
      turned = ($urandom_range(0, 2) == 0);
      full   = ($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 1) == 1) step = ($urandom_range(0, 1) == 1) ? 1 : -1;
      else step = int'($urandom_range(0, 15)) - 8;
    end
    send_pass(sw, press, turned, step, pick_temp(), pick_temp(), full);
  endtask

  // Walks through the menu, the clamps and the fill sequence by hand.
  task automatic run_directed();
    send_pass(0, 0, 0, 0, 0, 0, 0);
    // Switch on with extreme temperatures, then equality holds the outputs.
    send_pass(1, 0, 0, 0, TEMP_MIN, TEMP_MAX, 0);
    send_pass(1, 0, 0, 0, 560, 640, 0);
    send_pass(1, 0, 0, 0, TEMP_MAX, TEMP_MIN, 1);
    // Menu clamps at both ends; a press on the fill item with switch on is ignored.
    send_pass(1, 0, 1, 7, 559, 641, 0);
    send_pass(1, 1, 0, 0, 561, 639, 0);
    send_pass(1, 0, 1, -8, 560, 640, 0);
    // Water threshold edit down to the floor.
    send_pass(1, 1, 0, 0, 100, 100, 0);
    send_pass(1, 0, 1, 7, 672, 0, 0);
    send_pass(1, 0, 1, -8, 0, 0, 0);
    send_pass(1, 0, 1, -8, 0, 0, 0);
    send_pass(1, 0, 1, -8, 320, 0, 0);
    // Leave editing, move to the air item and edit it.
    send_pass(1, 1, 1, 1, 0, 0, 0);
    send_pass(1, 1, 1, 7, 0, 752, 0);
    send_pass(1, 1, 1, 1, 0, 753, 0);
    // Fill item: switch off, arm fill, turn while editing, tank full.
    send_pass(0, 0, 0, 0, 0, 0, 0);
    send_pass(0, 1, 0, 0, 0, 0, 0);
    send_pass(0, 0, 1, 5, 0, 0, 0);
    send_pass(0, 0, 0, 0, 0, 0, 1);
    // Fill mode holds after leaving the fill item until the switch moves.
    send_pass(0, 0, 1, -1, 0, 0, 0);
    send_pass(0, 0, 0, 0, TEMP_MAX, TEMP_MAX, 1);
    send_pass(1, 0, 0, 0, TEMP_MIN, TEMP_MIN, 0);
    send_pass(0, 0, 0, 0, 0, 0, 0);
  endtask

  // Stimulus and verdict.
  initial begin
    rst_n               <= 1'b0;
    cfg_we              <= 1'b0;
    cfg_idx             <= CFG_FLOOR;
    cfg_data            <= '0;
    pass_if.valid       <= 1'b0;
    pass_if.switch_on   <= 1'b0;
    pass_if.knob_press  <= 1'b0;
    pass_if.knob_turned <= 1'b0;
    pass_if.turn_step   <= '0;
    pass_if.water_temp  <= '0;
    pass_if.air_temp    <= '0;
    pass_if.tank_full   <= 1'b0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      if (ph == NUM_PHASES - 1) begin
        write_limits(int'($urandom_range(0, 127)), int'($urandom_range(0, 127)));
      end else begin
        write_limits(FLOOR_TBL[ph], CEIL_TBL[ph]);
      end
      send_pct  = SEND_TBL[ph];
      stall_pct = STALL_TBL[ph];
      if (ph == 0) run_directed();
      for (int n = 0; n < RANDOM_PASSES; n++) begin
        // Halfway through, let the block run dry once.
        if (n == RANDOM_PASSES / 2) drain();
        send_random();
      end
      drain();
    end
    repeat (4) @(posedge clk);

    $display("Checked %0d result words over %0d threshold limit settings (%0d in fill mode).",
             checked_words, NUM_PHASES, fill_words);
    $display("Idle mixes: none, sender gaps, result stalls and both; crossed limits included.");
    if (fail_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

/* files.f */
rtl/hmmc_pkg.sv
rtl/hmmc_if.sv
rtl/hmmc_pass.sv
rtl/heater_mode_menu_controller_top.sv
test/hmmc_pass_checker.sv
test/tb_heater_mode_menu_controller_top.sv
